[rtl/utf8d_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Result word layout for all decoder files; byte-class constants for the step.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int POINT_W = 21;
    localparam int SHOWN_W = 16;

    localparam logic [7:0] MASK_TOP1  = 8'h80;
    localparam logic [7:0] MASK_TOP2  = 8'hC0;
    localparam logic [7:0] MASK_TOP3  = 8'hE0;
    localparam logic [7:0] MASK_TOP4  = 8'hF0;
    localparam logic [7:0] MASK_TOP5  = 8'hF8;
    localparam logic [7:0] MARK_CONT  = 8'h80;
    localparam logic [7:0] MARK_LEAD2 = 8'hC0;
    localparam logic [7:0] MARK_LEAD3 = 8'hE0;
    localparam logic [7:0] MARK_LEAD4 = 8'hF0;
    localparam logic [7:0] MASK_CONT  = 8'h3F;
    localparam logic [7:0] MASK_LEAD2 = 8'h1F;
    localparam logic [7:0] MASK_LEAD3 = 8'h0F;
    localparam logic [7:0] MASK_LEAD4 = 8'h07;

    typedef struct packed {
        logic               point_ready;
        logic [POINT_W-1:0] code_point;
        logic               decode_error;
        logic               string_done;
        logic [SHOWN_W-1:0] points_so_far;
    } t_result;

endpackage
`default_nettype wire

[rtl/utf8d_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder step
// Holds the per-string decode state and forms the result word for one byte.
// ----------------------------------------------------------------------------
module utf8d_step #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_of_string,
    output utf8d_pkg::t_result     o_result
);
    import utf8d_pkg::*;

    logic [1:0]            r_pending, n_pending;
    logic [POINT_W-1:0]    r_partial, n_partial;
    logic                  r_halted, n_halted;
    logic [COUNT_BITS-1:0] r_count, n_count;

    logic                  ready;
    logic                  err;
    logic [POINT_W-1:0]    cp;
    logic [1:0]            pend;
    logic [POINT_W-1:0]    part;
    logic [COUNT_BITS-1:0] cnt;
    logic [SHOWN_W-1:0]    shown;

    always_comb begin
        ready = 1'b0;
        err   = 1'b0;
        cp    = '0;
        pend  = r_pending;
        part  = r_partial;
        cnt   = r_count;
        if (!r_halted) begin
            if (r_pending == 2'd0) begin
                if ((i_data_byte & MASK_TOP1) == 8'h00) begin
                    cp    = POINT_W'(i_data_byte);
                    ready = 1'b1;
                end else if ((i_data_byte & MASK_TOP3) == MARK_LEAD2) begin
                    part = POINT_W'(i_data_byte & MASK_LEAD2);
                    pend = 2'd1;
                end else if ((i_data_byte & MASK_TOP4) == MARK_LEAD3) begin
                    part = POINT_W'(i_data_byte & MASK_LEAD3);
                    pend = 2'd2;
                end else if ((i_data_byte & MASK_TOP5) == MARK_LEAD4) begin
                    part = POINT_W'(i_data_byte & MASK_LEAD4);
                    pend = 2'd3;
                end else begin
                    err = 1'b1;
                end
            end else if ((i_data_byte & MASK_TOP2) != MARK_CONT) begin
                err = 1'b1;
            end else begin
                part = {r_partial[POINT_W-7:0], i_data_byte[5:0]};
                pend = r_pending - 2'd1;
                if (pend == 2'd0) begin
                    cp    = part;
                    ready = 1'b1;
                end
            end
            if (!err && i_last_of_string && pend != 2'd0) begin
                err = 1'b1;
            end
            if (err) begin
                pend = 2'd0;
                part = '0;
            end
            if (ready && r_count != {COUNT_BITS{1'b1}}) begin
                cnt = r_count + 1'b1;
            end
        end
    end

    generate
        if (COUNT_BITS > SHOWN_W) begin : g_sat
            assign shown = (|cnt[COUNT_BITS-1:SHOWN_W]) ? {SHOWN_W{1'b1}} :
                                                          cnt[SHOWN_W-1:0];
        end else begin : g_ext
            assign shown = SHOWN_W'(cnt);
        end
    endgenerate

    always_comb begin
        if (i_last_of_string) begin
            n_pending = 2'd0;
            n_partial = '0;
            n_halted  = 1'b0;
            n_count   = '0;
        end else begin
            n_pending = pend;
            n_partial = part;
            n_halted  = r_halted | err;
            n_count   = cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
            r_halted  <= 1'b0;
            r_count   <= '0;
        end else if (i_en) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_halted  <= n_halted;
            r_count   <= n_count;
        end
    end

    assign o_result.point_ready   = ready;
    assign o_result.code_point    = cp;
    assign o_result.decode_error  = err;
    assign o_result.string_done   = i_last_of_string;
    assign o_result.points_so_far = shown;

endmodule
`default_nettype wire

[rtl/utf8d_out_buf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder output buffer
// Two-entry result queue: an output register backed by a skid register.
// ----------------------------------------------------------------------------
module utf8d_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire utf8d_pkg::t_result i_result,
    output logic                    o_full,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output utf8d_pkg::t_result      o_result
);
    import utf8d_pkg::*;

    logic    r_head_valid, n_head_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_head, n_head;
    t_result r_skid, n_skid;
    logic    pop;
    logic    head_free;

    assign pop       = r_head_valid && !i_stall;
    assign head_free = !r_head_valid || pop;

    always_comb begin
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        n_head       = r_head;
        n_skid       = r_skid;
        if (head_free) begin
            if (r_skid_valid) begin
                n_head       = r_skid;
                n_head_valid = 1'b1;
                n_skid       = i_result;
                n_skid_valid = i_push;
            end else begin
                n_head       = i_result;
                n_head_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_head_valid;
    assign o_result = r_head;

endmodule
`default_nettype wire

[rtl/utf8_codepoint_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 code point decoder
// Decodes a byte stream of strings into code points with error and count.
// ----------------------------------------------------------------------------
// Input words pass the input register, the decode step and the result queue.
// Throughput: one word per cycle unless a full result queue stalls the input.
// The input register and a two-entry result queue decouple the two sides.
// Reset is synchronous and clears all decode state and both queues.
module utf8_codepoint_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_of_string,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_point_ready,
    output logic [20:0]      o_code_point,
    output logic             o_decode_error,
    output logic             o_string_done,
    output logic [15:0]      o_points_so_far
);
    import utf8d_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       q_full;
    logic       adv;
    logic       accept;
    t_result    step_res;
    t_result    out_res;

    assign adv     = r_in_valid && !q_full;
    assign o_stall = r_in_valid && q_full;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept || adv) begin
            r_in_valid <= accept;
        end
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_of_string;
        end
    end

    utf8d_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (adv),
        .i_data_byte      (r_in_byte),
        .i_last_of_string (r_in_last),
        .o_result         (step_res)
    );

    utf8d_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (adv),
        .i_result (step_res),
        .o_full   (q_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_res)
    );

    assign o_point_ready   = out_res.point_ready;
    assign o_code_point    = out_res.code_point;
    assign o_decode_error  = out_res.decode_error;
    assign o_string_done   = out_res.string_done;
    assign o_points_so_far = out_res.points_so_far;

endmodule
`default_nettype wire
